@@ src/tcw_pkg.sv @@
// tcw_pkg: shared constants, command codes and state type of the text console writer
// no dependencies

package tcw_pkg;

   // default geometry of the console
   localparam int unsigned DEF_COLUMNS = 80;
   localparam int unsigned DEF_ROWS    = 25;

   // fixed field widths
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ATTR_W   = 8;
   localparam int unsigned CELL_W   = ATTR_W + CHAR_W;
   localparam int unsigned RADDR_W  = 11;
   localparam int unsigned CURSOR_W = 11;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // character and attribute constants
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK
   } state_type;

endpackage

@@ src/tcw_req_if.sv @@
// tcw_req_if: request channel of the text console writer, valid/ready plus command payload
// depends on tcw_pkg

interface tcw_req_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [CHAR_W-1:0]  char_code;
   logic [RADDR_W-1:0] read_address;

   modport source (output valid, cmd, char_code, read_address, input ready);
   modport sink   (input valid, cmd, char_code, read_address, output ready);
endinterface

@@ src/tcw_rsp_if.sv @@
// tcw_rsp_if: response channel of the text console writer, valid/ready plus result payload
// depends on tcw_pkg

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_position;
   logic [CELL_W-1:0]   read_data;
   logic                scrolled;

   modport source (output valid, cursor_position, read_data, scrolled, input ready);
   modport sink   (input valid, cursor_position, read_data, scrolled, output ready);
endinterface

@@ src/text_console_writer_core.sv @@
// text_console_writer_core: character-cell text console with cursor, scroll and clear
// depends on tcw_pkg, tcw_req_if, tcw_rsp_if and tcw_cell_store
//
// channel   direction  handshake            payload
// req_if    in         valid/ready          cmd, char_code, read_address
// rsp_if    out        valid/ready          cursor_position, read_data, scrolled
// csr_*     in         write enable only    cell_attribute (8 bits)
//
// put of any byte without scroll, or an unused cmd: result loaded from ST_IDLE
// read: result taken in ST_READ, from the registered read port of the cell store
// clear: every cell blanked in ST_BLANK, one cell per cycle through the single write port
// put that scrolls: row copy in ST_COPY, then bottom row blanked in ST_BLANK
// after reset the store is swept to blanks in ST_INIT; req_if.ready stays low
// a stalled result sits in the output register; a new item is taken once the slot frees

module text_console_writer_core import tcw_pkg::*; #(
   parameter int unsigned COLUMNS = DEF_COLUMNS,
   parameter int unsigned ROWS    = DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data,
   tcw_req_if.sink           req_if,
   tcw_rsp_if.source         rsp_if
);

   localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
   localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
   localparam int unsigned POS_W      = $clog2(CELL_COUNT + 1);
   localparam int unsigned COL_W      = $clog2(COLUMNS + 1);
   localparam int unsigned ROW_W      = $clog2(ROWS + 1);

   localparam logic [POS_W-1:0] POS_COUNT  = POS_W'(CELL_COUNT);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(CELL_COUNT - 1);
   localparam logic [POS_W-1:0] POS_COLS   = POS_W'(COLUMNS);
   localparam logic [POS_W-1:0] POS_BOTTOM = POS_W'(CELL_COUNT - COLUMNS);
   localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);

   // state and registers
   state_type state_ff, state_in;

   logic [ATTR_W-1:0]   attr_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    ptr_ff, ptr_in;
   logic                copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]   copy_dst_ff;
   logic                scroll_ff;
   logic                rd_ok_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_scroll_ff, rsp_scroll_in;

   // cell store ports
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_ra;
   logic [CELL_W-1:0] mem_rd;

   // decode of the incoming item
   logic accept;
   logic is_put, is_read, is_clear;
   logic is_nl, is_print, wrap, row_adv, need_scroll;
   logic rsp_load;
   logic read_ok;
   logic ptr_at_last, ptr_at_count;

   tcw_cell_store #(
      .DEPTH (CELL_COUNT)
   ) u_store (
      .clock         (clock),
      .write_enable  (mem_we),
      .write_address (mem_wa),
      .write_data    (mem_wd),
      .read_enable   (mem_re),
      .read_address  (mem_ra),
      .read_data     (mem_rd)
   );

   // item decode, cursor stepping on a put
   always_comb begin
      is_put   = (req_if.cmd == CMD_PUT);
      is_read  = (req_if.cmd == CMD_READ);
      is_clear = (req_if.cmd == CMD_CLEAR);
      is_nl    = (req_if.char_code == NEWLINE_CHAR);
      // 0x20..0x7f; the top bit set means a negative signed char, ignored
      is_print = (req_if.char_code >= BLANK_CHAR) && !req_if.char_code[CHAR_W-1];
      wrap     = is_print && (col_ff == COL_LAST);
      row_adv  = is_nl || wrap;
      need_scroll = row_adv && (row_ff == ROW_LAST);
      read_ok  = (32'(req_if.read_address) < CELL_COUNT);
      ptr_at_last  = (ptr_ff == POS_LAST);
      ptr_at_count = (ptr_ff == POS_COUNT);

      col_in = col_ff;
      row_in = row_ff;
      pos_in = pos_ff;
      if (accept && is_put) begin
         if (need_scroll) begin
            // cursor lands at the start of the last row
            col_in = '0;
            row_in = ROW_LAST;
            pos_in = POS_BOTTOM;
         end else if (row_adv) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
            pos_in = wrap ? pos_ff + POS_W'(1) : pos_ff + POS_COLS - POS_W'(col_ff);
         end else if (is_print) begin
            col_in = col_ff + COL_W'(1);
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (ptr_at_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_put && need_scroll) state_in = ST_COPY;
               else if (is_read) state_in = ST_READ;
               else if (is_clear) state_in = ST_BLANK;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_COPY: begin
            if (ptr_at_count) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (ptr_at_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: handshake, store ports, sweep pointer, result register loading
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
      accept       = req_if.valid && req_if.ready;

      mem_we = 1'b0;
      mem_wa = ptr_ff[ADDR_W-1:0];
      mem_wd = {attr_ff, BLANK_CHAR};
      mem_re = 1'b0;
      mem_ra = ptr_ff[ADDR_W-1:0];
      ptr_in = ptr_ff;
      copy_pend_in = 1'b0;

      rsp_load      = 1'b0;
      rsp_pos_in    = CURSOR_W'(pos_ff);
      rsp_data_in   = '0;
      rsp_scroll_in = 1'b0;

      case (state_ff)
         ST_INIT: begin
            // power-up blanking always uses the reset attribute
            mem_we = 1'b1;
            mem_wd = {RESET_ATTR, BLANK_CHAR};
            ptr_in = ptr_ff + POS_W'(1);
         end
         ST_IDLE: begin
            // a printable byte goes straight to the cursor cell, no read needed
            mem_we = accept && is_put && is_print;
            mem_wa = pos_ff[ADDR_W-1:0];
            mem_wd = {attr_ff, req_if.char_code};
            mem_re = accept && is_read;
            mem_ra = ADDR_W'(req_if.read_address);
            ptr_in = (is_put && need_scroll) ? POS_COLS : '0;
            // results that need no memory pass are ready at once
            rsp_load   = accept && ((is_put && !need_scroll) || (!is_read && !is_clear && !is_put));
            rsp_pos_in = CURSOR_W'(pos_in);
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_data_in = rd_ok_ff ? mem_rd : '0;
         end
         ST_COPY: begin
            // read cell ptr, write it one row up in the following cycle
            mem_re       = !ptr_at_count;
            copy_pend_in = !ptr_at_count;
            mem_we       = copy_pend_ff;
            mem_wa       = copy_dst_ff;
            mem_wd       = mem_rd;
            ptr_in       = ptr_at_count ? POS_BOTTOM : ptr_ff + POS_W'(1);
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + POS_W'(1);
            rsp_load      = ptr_at_last;
            rsp_scroll_in = scroll_ff;
         end
         default: begin
            ptr_in = '0;
         end
      endcase

      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         attr_ff      <= RESET_ATTR;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         ptr_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         ptr_ff       <= ptr_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) attr_ff <= csr_write_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_COPY) copy_dst_ff <= ADDR_W'(ptr_ff - POS_COLS);
      if (accept) begin
         scroll_ff <= is_put && need_scroll;
         rd_ok_ff  <= read_ok;
      end
      if (rsp_load) begin
         rsp_pos_ff    <= rsp_pos_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_scroll_ff <= rsp_scroll_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.cursor_position = rsp_pos_ff;
   assign rsp_if.read_data       = rsp_data_ff;
   assign rsp_if.scrolled        = rsp_scroll_ff;

   // cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS))
      else $error("cursor outside the screen");

   // linear cursor tracks row and column
   a_cursor_linear: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff))
      else $error("linear cursor out of step with row and column");

   // no item taken while a result is held and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !accept)
      else $error("item accepted over a stalled result");

   // a clear or scroll pass ends with exactly one result, except the power-up sweep
   a_pass_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLANK && ptr_at_last) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("memory pass ended without a result");

endmodule

@@ src/tcw_cell_store.sv @@
// tcw_cell_store: character cell memory, one write port and one read port, registered read
// depends on tcw_pkg

module tcw_cell_store import tcw_pkg::*; #(
   parameter int unsigned DEPTH = DEF_COLUMNS * DEF_ROWS,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [CELL_W-1:0] write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_address,
   output logic [CELL_W-1:0] read_data
);

   logic [CELL_W-1:0] cells [DEPTH];
   logic [CELL_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         cells[write_address] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= cells[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ test/console_result_checker.sv @@
`timescale 1ns / 1ps
// console_result_checker: shadow cell store and cursor of the text console, in-order result check
// depends on tcw_pkg, tcw_req_if and tcw_rsp_if

module console_result_checker import tcw_pkg::*; #(
   parameter int unsigned COLUMNS = DEF_COLUMNS,
   parameter int unsigned ROWS    = DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data,
   tcw_req_if                req_mon,
   tcw_rsp_if                rsp_mon,
   output int                failures,
   output int                outstanding
);

   localparam int unsigned       CELL_COUNT     = COLUMNS * ROWS;
   localparam logic [CHAR_W-1:0] PRINTABLE_LAST = 8'h7F;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_position;
      logic [CELL_W-1:0]   read_data;
      logic                scrolled;
   } console_result_type;

   logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
   logic [6:0]         shadow_column;
   logic [4:0]         shadow_row;
   logic [ATTR_W-1:0]  shadow_attr;
   console_result_type expected_results [$];

   task automatic blank_screen();
      for (int unsigned i = 0; i < CELL_COUNT; i++)
         shadow_cells[i] = {shadow_attr, BLANK_CHAR};
   endtask

   // one command against the shadow state, giving the result it must produce
   task automatic apply_console_command(
      input  logic [CMD_W-1:0]   cmd,
      input  logic [CHAR_W-1:0]  ch,
      input  logic [RADDR_W-1:0] addr,
      output console_result_type res
   );
      int unsigned col;
      int unsigned row;
      res = '0;
      col = shadow_column;
      row = shadow_row;
      case (cmd)
         CMD_PUT: begin
            if (ch == NEWLINE_CHAR) begin
               col = 0;
               row++;
            end
            if (ch >= BLANK_CHAR && ch <= PRINTABLE_LAST) begin
               if (row * COLUMNS + col < CELL_COUNT)
                  shadow_cells[row * COLUMNS + col] = {shadow_attr, ch};
               col++;
            end
            if (col >= COLUMNS) begin
               col = 0;
               row++;
            end
            // past the last row: move everything up one row, blank the bottom one
            if (row >= ROWS) begin
               for (int unsigned i = 0; i < CELL_COUNT - COLUMNS; i++)
                  shadow_cells[i] = shadow_cells[i + COLUMNS];
               for (int unsigned i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  shadow_cells[i] = {shadow_attr, BLANK_CHAR};
               row = ROWS - 1;
               col = 0;
               res.scrolled = 1'b1;
            end
         end
         CMD_READ: begin
            if (addr < CELL_COUNT)
               res.read_data = shadow_cells[addr];
         end
         CMD_CLEAR: begin
            blank_screen();
         end
         default: begin
         end
      endcase
      shadow_column = 7'(col);
      shadow_row = 5'(row);
      res.cursor_position = CURSOR_W'(row * COLUMNS + col);
   endtask

   always @(posedge clock) begin
      console_result_type got;
      console_result_type want;
      console_result_type predicted;
      if (reset) begin
         shadow_attr = RESET_ATTR;
         shadow_column = '0;
         shadow_row = '0;
         blank_screen();
         expected_results.delete();
         failures = 0;
      end else begin
         if (csr_write_enable)
            shadow_attr = csr_write_data;
         // results first: a result never belongs to an item taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.cursor_position = rsp_mon.cursor_position;
            got.read_data = rsp_mon.read_data;
            got.scrolled = rsp_mon.scrolled;
            if (expected_results.size() == 0) begin
               $error("result with no item waiting: cursor_position %0d read_data %h scrolled %0d",
                      got.cursor_position, got.read_data, got.scrolled);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (got.cursor_position !== want.cursor_position) begin
                  $error("cursor_position expected %0d got %0d",
                         want.cursor_position, got.cursor_position);
                  failures++;
               end
               if (got.read_data !== want.read_data) begin
                  $error("read_data expected %h got %h", want.read_data, got.read_data);
                  failures++;
               end
               if (got.scrolled !== want.scrolled) begin
                  $error("scrolled expected %0d got %0d", want.scrolled, got.scrolled);
                  failures++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_console_command(req_mon.cmd, req_mon.char_code, req_mon.read_address,
                                  predicted);
            expected_results.push_back(predicted);
         end
      end
      outstanding = expected_results.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench: stimulus, idling and verdict for text_console_writer_core
// depends on tcw_pkg, tcw_req_if, tcw_rsp_if, console_result_checker and the block itself

module testbench import tcw_pkg::*; ();

   localparam int unsigned        CELL_COUNT      = DEF_COLUMNS * DEF_ROWS;
   localparam int unsigned        ADDR_TOP        = (1 << RADDR_W) - 1;
   localparam logic [CMD_W-1:0]   CMD_UNUSED      = 2'd3;
   localparam logic [CHAR_W-1:0]  PRINTABLE_FIRST = BLANK_CHAR;
   localparam logic [CHAR_W-1:0]  PRINTABLE_LAST  = 8'h7F;
   localparam int                 ITEMS_PER_PHASE = 250;
   // a scroll or clear walks the whole store, so the drain and the watchdog cover that many times
   localparam int                 DRAIN_CYCLES    = CELL_COUNT + 100;
   localparam int                 STALL_LIMIT     = 20000;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;
   int                failures;
   int                outstanding;
   int                items_sent;
   int                stall_cycles;
   bit                steady_sender;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_writer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_if),
      .rsp_if           (rsp_if)
   );

   console_result_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // mostly no gap or a short one, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_console_item(
      input logic [CMD_W-1:0]   cmd,
      input logic [CHAR_W-1:0]  ch,
      input logic [RADDR_W-1:0] addr
   );
      int  gap;
      bit  ignored;
      gap = steady_sender ? 0 : idle_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.char_code <= ch;
      req_if.read_address <= addr;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      // puts of non-printable bytes other than newline, and the unused command, leave the block untouched
      ignored = (cmd == CMD_UNUSED) ||
                (cmd == CMD_PUT && ch != NEWLINE_CHAR &&
                 (ch < PRINTABLE_FIRST || ch > PRINTABLE_LAST));
      if (!ignored)
         items_sent++;
   endtask

   // attribute writes only once every result is back and nothing is offered
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result side: runs of ready, broken by random stalls, sometimes long open stretches
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(100, 400)) @(negedge clock);
         else
            repeat ($urandom_range(1, 20)) @(negedge clock);
         gap = idle_gap();
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // watchdog: too many cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL text_console_writer_core");
         $finish;
      end
   end

   initial begin
      logic [ATTR_W-1:0] phase_attr [4];
      int                phase_end;
      int                pick;
      int                line_len;

      // every input known from time zero
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_PUT;
      req_if.char_code = '0;
      req_if.read_address = '0;
      items_sent = 0;
      steady_sender = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // the block's own clearing sweep after reset is covered by waiting on ready

      // directed: reset contents at both ends of the store and beyond it
      send_console_item(CMD_READ, 8'h00, RADDR_W'(0));
      send_console_item(CMD_READ, 8'hFF, RADDR_W'(CELL_COUNT - 1));
      send_console_item(CMD_READ, 8'h00, RADDR_W'(CELL_COUNT));
      send_console_item(CMD_READ, 8'hFF, RADDR_W'(ADDR_TOP));
      // printable bounds, ignored control and high bytes, newline
      send_console_item(CMD_PUT, 8'h41, RADDR_W'(ADDR_TOP));
      send_console_item(CMD_PUT, PRINTABLE_FIRST, RADDR_W'(0));
      send_console_item(CMD_PUT, PRINTABLE_LAST, RADDR_W'(0));
      send_console_item(CMD_PUT, 8'h1F, RADDR_W'(0));
      send_console_item(CMD_PUT, 8'h00, RADDR_W'(0));
      send_console_item(CMD_PUT, 8'h80, RADDR_W'(0));
      send_console_item(CMD_PUT, 8'hFF, RADDR_W'(ADDR_TOP));
      send_console_item(CMD_PUT, NEWLINE_CHAR, RADDR_W'(0));
      send_console_item(CMD_PUT, 8'h7A, RADDR_W'(0));
      // what was written lands where the cursor was
      send_console_item(CMD_READ, 8'h00, RADDR_W'(0));
      send_console_item(CMD_READ, 8'h00, RADDR_W'(1));
      send_console_item(CMD_READ, 8'h00, RADDR_W'(2));
      send_console_item(CMD_READ, 8'h00, RADDR_W'(DEF_COLUMNS));
      // unused command, then clear keeps the cursor
      send_console_item(CMD_UNUSED, 8'hFF, RADDR_W'(ADDR_TOP));
      send_console_item(CMD_CLEAR, 8'h00, RADDR_W'(0));
      send_console_item(CMD_READ, 8'h00, RADDR_W'(0));
      send_console_item(CMD_READ, 8'h00, RADDR_W'(DEF_COLUMNS));

      // random part in phases, each with its own attribute, extremes first
      phase_attr[0] = 8'hFF;
      phase_attr[1] = 8'h00;
      phase_attr[2] = ATTR_W'($urandom);
      phase_attr[3] = ATTR_W'($urandom);
      for (int p = 0; p < 4; p++) begin
         write_attribute(phase_attr[p]);
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            steady_sender = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               // a line of text: mostly short, sometimes past the right margin
               line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100)
                                                      : $urandom_range(0, 12);
               repeat (line_len)
                  send_console_item(CMD_PUT,
                                    CHAR_W'($urandom_range(PRINTABLE_FIRST, PRINTABLE_LAST)),
                                    RADDR_W'($urandom));
               if ($urandom_range(0, 4) != 0)
                  send_console_item(CMD_PUT, NEWLINE_CHAR, RADDR_W'($urandom));
            end else if (pick < 80) begin
               // display refresh reads, a few past the end of the store
               repeat ($urandom_range(1, 6))
                  send_console_item(CMD_READ, CHAR_W'($urandom),
                                    ($urandom_range(0, 6) != 0)
                                       ? RADDR_W'($urandom_range(0, CELL_COUNT - 1))
                                       : RADDR_W'($urandom_range(CELL_COUNT, ADDR_TOP)));
            end else if (pick < 83) begin
               send_console_item(CMD_CLEAR, CHAR_W'($urandom), RADDR_W'($urandom));
            end else begin
               // noise: any command, any byte, any address
               repeat ($urandom_range(1, 4))
                  send_console_item(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom),
                                    RADDR_W'($urandom));
            end
         end
      end

      // drain: everything back, then room for a late stray result
      steady_sender = 1'b0;
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("PASS text_console_writer_core");
      else
         $display("FAIL text_console_writer_core");
      $finish;
   end

endmodule
